[design/nmbd_pkg.sv]
// ----------------------------------------------------------------------------
// nmbd_pkg
// Shared types, constants and helpers for the masked 2x2 box downsampler.
// ----------------------------------------------------------------------------
package nmbd_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 34;
   localparam int PAIR_SUM_W  = 33;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int DIV_STEPS   = 9;
   localparam int STEP_W      = 4;
   localparam int MAG_W       = 36;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_NODATA_VALUE,
      CSR_NODATA_ENABLE
   } nmbd_csr_type;

   typedef struct packed {
      logic [12:0]                src_width;
      logic [15:0]                src_height;
      logic signed [SAMPLE_W-1:0] nodata_value;
      logic                       nodata_enable;
   } nmbd_cfg_type;

   typedef struct packed {
      logic [1:0]                   cnt;
      logic signed [PAIR_SUM_W-1:0] sum;
   } nmbd_pair_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [2:0]              cnt;
      logic                    row_end;
      logic                    frame_end;
   } nmbd_job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } nmbd_state_type;

   // one radix-16 digit of a divide by three: returns {quotient digit, remainder}
   function automatic logic [5:0] div3_nibble(input logic [1:0] rem, input logic [3:0] nib);
      logic [2:0] r;
      logic [3:0] q;
      r = {1'b0, rem};
      q = '0;
      for (int i = 3; i >= 0; i--) begin
         r = {r[1:0], nib[i]};
         if (r >= 3'd3) begin
            q[i] = 1'b1;
            r    = r - 3'd3;
         end
      end
      return {q, r[1:0]};
   endfunction

endpackage

[design/nodata_masked_box_downsample.sv]
// ----------------------------------------------------------------------------
// nodata_masked_box_downsample
// 2x2 box-filter downsampler with optional nodata masking.
//
// Source pixels enter row-major on the req_ channel (valid/ready), one per
// cycle at most. Each completed 2x2 block gives one rsp_ item: the mean of
// its valid pixels, truncated toward zero, or the nodata value with
// rsp_all_missing set. An odd last row or column is replicated. rsp_row_end
// and rsp_frame_end mark the last block of an output row and of the frame.
// Frame size and masking are set through the csr_ write port; the user
// must do so only while idle, which the block does not enforce.
// The front accepts one sample per cycle while req_ready is high. A block
// passes the block stage and the queue to the back divider, which handles
// one result at a time; when exactly three pixels of a block are valid it
// divides by three, one radix-16 digit per cycle. A 4-entry queue absorbs
// bursts. When the receiver stalls the result holds, the queue fills and
// then req_ready drops. Reset clears position, queue and output; the row
// store needs no clearing.
// ----------------------------------------------------------------------------
module nodata_masked_box_downsample import nmbd_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_all_missing,
   output logic                       rsp_row_end,
   output logic                       rsp_frame_end,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_wdata
);

   nmbd_cfg_type cfg_ff, cfg_in;
   logic         push_valid, push_ready, pop_valid, pop_ready;
   nmbd_job_type push_job, pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (nmbd_csr_type'(csr_index))
            CSR_SRC_WIDTH:     cfg_in.src_width     = csr_wdata[12:0];
            CSR_SRC_HEIGHT:    cfg_in.src_height    = csr_wdata[15:0];
            CSR_NODATA_VALUE:  cfg_in.nodata_value  = csr_wdata;
            CSR_NODATA_ENABLE: cfg_in.nodata_enable = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width     <= 13'd4096;
         cfg_ff.src_height    <= 16'd1;
         cfg_ff.nodata_value  <= '0;
         cfg_ff.nodata_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nmbd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   nmbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   nmbd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .nodata_value    (cfg_ff.nodata_value),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_job         (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average     (rsp_average),
      .rsp_all_missing (rsp_all_missing),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end)
   );

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_missing_needs_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_missing |->
         cfg_ff.nodata_enable && rsp_average == cfg_ff.nodata_value)
      else $error("all-missing result without masking or with wrong value");

   a_frame_end_is_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end not at a row end");

   a_queue_full_stalls: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |-> !req_ready)
      else $error("sample taken while the block stage is stalled");

endmodule

[design/nmbd_ram.sv]
// ----------------------------------------------------------------------------
// nmbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmbd_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[design/nmbd_front.sv]
// ----------------------------------------------------------------------------
// nmbd_front
// Takes source pixels, forms horizontal pairs, keeps the upper row of pairs
// in the row store and hands finished blocks (sum and count) to the queue.
// ----------------------------------------------------------------------------
module nmbd_front import nmbd_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  nmbd_cfg_type               cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       push_valid,
   input  logic                       push_ready,
   output nmbd_job_type               push_job
);

   localparam int COL_W       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W       = (COL_W + 1 > 13) ? COL_W + 1 : 13;
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   logic [COL_W-1:0]          col_ff, col_in;
   logic [15:0]               row_ff, row_in;
   logic signed [SAMPLE_W-1:0] held_sample_ff, held_sample_in;
   logic                      held_valid_ff, held_valid_in;
   logic                      b_valid_ff, b_valid_in;
   nmbd_pair_type             b_pair_ff, b_pair_in;
   logic                      b_self_ff, b_self_in;
   logic                      b_row_end_ff, b_row_end_in;
   logic                      b_frame_end_ff, b_frame_end_in;

   logic [CMP_W-1:0]          w_ext, w_nz, w_sat;
   logic [COL_W-1:0]          col_last;
   logic [15:0]               h_nz, row_last;
   logic                      last_col, last_row, upper, have_pair, produce;
   logic                      accept, pix_valid;
   nmbd_pair_type             pair;
   nmbd_pair_type             q_pair, ram_pair;
   logic [ADDR_W-1:0]         slot;
   logic                      ram_we, ram_re;
   logic [$bits(nmbd_pair_type)-1:0] ram_rdata;

   // effective frame size
   always_comb begin
      w_ext    = CMP_W'(cfg.src_width);
      w_nz     = (w_ext == '0) ? CMP_W'(1) : w_ext;
      w_sat    = (w_nz > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_nz;
      col_last = COL_W'(w_sat - CMP_W'(1));
      h_nz     = (cfg.src_height == '0) ? 16'd1 : cfg.src_height;
      row_last = h_nz - 16'd1;
      last_col = col_ff >= col_last;
      last_row = row_ff >= row_last;
      upper    = ~row_ff[0];
   end

   assign req_ready = ~b_valid_ff | push_ready;
   assign accept    = req_valid & req_ready;
   assign pix_valid = ~(cfg.nodata_enable & (req_sample == cfg.nodata_value));
   assign slot      = ADDR_W'(col_ff >> 1);

   // horizontal pair
   always_comb begin
      pair      = '0;
      have_pair = 1'b0;
      if (col_ff[0]) begin
         pair.sum  = (held_valid_ff ? {held_sample_ff[SAMPLE_W-1], held_sample_ff}
                                    : PAIR_SUM_W'(0))
                   + (pix_valid ? {req_sample[SAMPLE_W-1], req_sample} : PAIR_SUM_W'(0));
         pair.cnt  = {1'b0, held_valid_ff} + {1'b0, pix_valid};
         have_pair = 1'b1;
      end else if (last_col) begin
         pair.sum  = pix_valid ? {req_sample, 1'b0} : PAIR_SUM_W'(0);
         pair.cnt  = pix_valid ? 2'd2 : 2'd0;
         have_pair = 1'b1;
      end
      produce = have_pair & ~(upper & ~last_row);
   end

   assign ram_we = accept & have_pair & upper & ~last_row;
   assign ram_re = accept & have_pair & ~upper;

   nmbd_ram #(
      .WIDTH ($bits(nmbd_pair_type)),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot),
      .wdata (pair),
      .re    (ram_re),
      .raddr (slot),
      .rdata (ram_rdata)
   );

   // position and held pixel
   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      held_sample_in = held_sample_ff;
      held_valid_in  = held_valid_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         if (!have_pair) begin
            held_sample_in = req_sample;
            held_valid_in  = pix_valid;
         end
      end
   end

   // block stage, registered together with the store read
   always_comb begin
      b_valid_in     = accept ? produce : (b_valid_ff & ~push_ready);
      b_pair_in      = accept ? pair : b_pair_ff;
      b_self_in      = accept ? upper : b_self_ff;
      b_row_end_in   = accept ? last_col : b_row_end_ff;
      b_frame_end_in = accept ? (last_col & last_row) : b_frame_end_ff;
   end

   always_comb begin
      ram_pair          = nmbd_pair_type'(ram_rdata);
      q_pair            = b_self_ff ? b_pair_ff : ram_pair;
      push_valid        = b_valid_ff;
      push_job.sum      = {b_pair_ff.sum[PAIR_SUM_W-1], b_pair_ff.sum}
                        + {q_pair.sum[PAIR_SUM_W-1], q_pair.sum};
      push_job.cnt      = {1'b0, b_pair_ff.cnt} + {1'b0, q_pair.cnt};
      push_job.row_end  = b_row_end_ff;
      push_job.frame_end = b_frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         held_sample_ff <= '0;
         held_valid_ff  <= 1'b0;
         b_valid_ff     <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         held_sample_ff <= held_sample_in;
         held_valid_ff  <= held_valid_in;
         b_valid_ff     <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_pair_ff      <= b_pair_in;
      b_self_ff      <= b_self_in;
      b_row_end_ff   <= b_row_end_in;
      b_frame_end_ff <= b_frame_end_in;
   end

endmodule

[design/nmbd_queue.sv]
// ----------------------------------------------------------------------------
// nmbd_queue
// Small flop-based queue of block jobs between front and back.
// ----------------------------------------------------------------------------
module nmbd_queue import nmbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  nmbd_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output nmbd_job_type pop_job
);

   nmbd_job_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;
   assign pop_job    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/nmbd_back.sv]
// ----------------------------------------------------------------------------
// nmbd_back
// Divides each block sum by its valid count, truncating toward zero, or gives
// nodata for a zero count; the output register holds the result until taken.
// ----------------------------------------------------------------------------
module nmbd_back import nmbd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] nodata_value,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  nmbd_job_type               pop_job,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_all_missing,
   output logic                       rsp_row_end,
   output logic                       rsp_frame_end
);

   nmbd_state_type            state_ff, state_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [SAMPLE_W-1:0]       quo_ff, quo_in;
   logic [1:0]                rem_ff, rem_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic                      miss_ff, miss_in;
   logic                      row_end_ff, row_end_in;
   logic                      frame_end_ff, frame_end_in;
   logic                      out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_avg_ff, out_avg_in;
   logic                      out_miss_ff, out_miss_in;
   logic                      out_row_end_ff, out_row_end_in;
   logic                      out_frame_end_ff, out_frame_end_in;

   logic [SUM_W-1:0]          job_mag;
   logic [5:0]                digit;
   logic                      out_free;

   assign out_free = ~out_valid_ff | rsp_ready;
   assign job_mag  = pop_job.sum[SUM_W-1] ? SUM_W'(-pop_job.sum) : SUM_W'(pop_job.sum);
   assign digit    = div3_nibble(rem_ff, mag_ff[MAG_W-1 -: 4]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_job.cnt == 3'd3) ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop_ready        = 1'b0;
      mag_in           = mag_ff;
      quo_in           = quo_ff;
      rem_in           = rem_ff;
      step_in          = step_ff;
      neg_in           = neg_ff;
      miss_in          = miss_ff;
      row_end_in       = row_end_ff;
      frame_end_in     = frame_end_ff;
      out_valid_in     = out_valid_ff & ~rsp_ready;
      out_avg_in       = out_avg_ff;
      out_miss_in      = out_miss_ff;
      out_row_end_in   = out_row_end_ff;
      out_frame_end_in = out_frame_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready    = 1'b1;
            neg_in       = pop_job.sum[SUM_W-1];
            miss_in      = pop_job.cnt == 3'd0;
            row_end_in   = pop_job.row_end;
            frame_end_in = pop_job.frame_end;
            mag_in       = MAG_W'(job_mag);
            rem_in       = 2'd0;
            step_in      = '0;
            case (pop_job.cnt)
               3'd2:    quo_in = job_mag[SAMPLE_W:1];
               3'd3:    quo_in = '0;
               3'd4:    quo_in = job_mag[SAMPLE_W+1:2];
               default: quo_in = job_mag[SAMPLE_W-1:0];
            endcase
         end
         ST_DIV: begin
            mag_in  = {mag_ff[MAG_W-5:0], 4'd0};
            quo_in  = {quo_ff[SAMPLE_W-5:0], digit[5:2]};
            rem_in  = digit[1:0];
            step_in = step_ff + STEP_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_avg_in       = miss_ff ? nodata_value
                                          : (neg_ff ? SAMPLE_W'(-quo_ff) : quo_ff);
               out_miss_in      = miss_ff;
               out_row_end_in   = row_end_ff;
               out_frame_end_in = frame_end_ff;
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      quo_ff           <= quo_in;
      rem_ff           <= rem_in;
      step_ff          <= step_in;
      neg_ff           <= neg_in;
      miss_ff          <= miss_in;
      row_end_ff       <= row_end_in;
      frame_end_ff     <= frame_end_in;
      out_avg_ff       <= out_avg_in;
      out_miss_ff      <= out_miss_in;
      out_row_end_ff   <= out_row_end_in;
      out_frame_end_ff <= out_frame_end_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_average     = out_avg_ff;
   assign rsp_all_missing = out_miss_ff;
   assign rsp_row_end     = out_row_end_ff;
   assign rsp_frame_end   = out_frame_end_ff;

endmodule
